// File: rtl/printf_integer_formatter_defines.svh
// Assertion macros for the printf integer formatter.
// Included by printf_integer_formatter, which carries concurrent checks; depends on nothing.
`ifndef PRINTF_INTEGER_FORMATTER_DEFINES_SVH
`define PRINTF_INTEGER_FORMATTER_DEFINES_SVH
`ifndef SYNTHESIS
`define PIF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pif: check failed");
`define PIF_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("pif: sequencing check failed");
`else
`define PIF_ASSERT(lbl, clk, rstn, prop)
`define PIF_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// File: rtl/pif_pkg.sv
// Shared constants, types and helpers for the printf integer formatter.
// Used by pif_digit_unit and printf_integer_formatter; depends on nothing.
package pif_pkg;

    localparam int ARG_BITS   = 32;
    localparam int ARG_W      = (ARG_BITS < 32) ? ARG_BITS : 32;
    localparam bit ARG_SIGNED = (ARG_BITS <= 32);
    // digits of 2^ARG_W - 1: floor(ARG_W * log10(2)) + 1
    localparam int DEC_DIGITS = (ARG_W * 1233) / 4096 + 1;
    localparam int HEX_DIGITS = (ARG_W + 3) / 4;
    localparam int DIG_N      = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DIG_W      = 4 * DIG_N;
    localparam int ITER_W     = $clog2(ARG_W + 1);
    localparam int CNT_W      = $clog2(DIG_N + 1);

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_D = 8'h64;
    localparam logic [7:0] CH_LOWER_I = 8'h69;
    localparam logic [7:0] CH_LOWER_P = 8'h70;
    localparam logic [7:0] CH_LOWER_U = 8'h75;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    typedef struct packed {
        logic load_dec;
        logic load_hex;
        logic shift_digit;
    } pif_dig_cmd_t;

    typedef struct packed {
        logic       dabble_done;
        logic [3:0] top_digit;
        logic       last_digit;
    } pif_dig_stat_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] r;
        if (d < 4'd10)
        begin
            r = CH_ZERO + {4'b0000, d};
        end
        else
        begin
            r = (upper ? CH_UPPER_A : CH_LOWER_A) + {4'b0000, d} - 8'd10;
        end
        return r;
    endfunction

endpackage

// File: rtl/pif_digit_unit.sv
// Digit register of the formatter: bit-serial binary to BCD conversion
// (shift and add three) and a nibble shifter for emission. Depends on pif_pkg.
module pif_digit_unit
    import pif_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  pif_dig_cmd_t     cmd,
    input  logic [ARG_W-1:0] load_value,
    output pif_dig_stat_t    stat
);

    logic [DIG_W-1:0]  dig_reg, dig_next, adj;
    logic [ARG_W-1:0]  bin_reg, bin_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [CNT_W-1:0]  dcnt_reg, dcnt_next;

    // add three to every BCD digit of five or more before the shift
    always_comb
    begin
        for (int k = 0; k < DIG_N; k++)
        begin
            adj[4*k +: 4] = (dig_reg[4*k +: 4] >= 4'd5) ? dig_reg[4*k +: 4] + 4'd3
                                                          : dig_reg[4*k +: 4];
        end
    end

    always_comb
    begin
        dig_next  = dig_reg;
        bin_next  = bin_reg;
        iter_next = iter_reg;
        dcnt_next = dcnt_reg;
        if (cmd.load_dec)
        begin
            dig_next  = '0;
            bin_next  = load_value;
            iter_next = ITER_W'(ARG_W);
            dcnt_next = CNT_W'(DIG_N);
        end
        else if (cmd.load_hex)
        begin
            dig_next  = DIG_W'(load_value);
            iter_next = '0;
            dcnt_next = CNT_W'(DIG_N);
        end
        else if (iter_reg != '0)
        begin
            dig_next  = {adj[DIG_W-2:0], bin_reg[ARG_W-1]};
            bin_next  = {bin_reg[ARG_W-2:0], 1'b0};
            iter_next = iter_reg - ITER_W'(1);
        end
        else if (cmd.shift_digit)
        begin
            dig_next  = {dig_reg[DIG_W-5:0], 4'b0000};
            dcnt_next = dcnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            dcnt_reg <= '0;
        end
        else
        begin
            iter_reg <= iter_next;
            dcnt_reg <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        bin_reg <= bin_next;
    end

    assign stat.dabble_done = (iter_reg == '0);
    assign stat.top_digit   = dig_reg[DIG_W-1 -: 4];
    assign stat.last_digit  = (dcnt_reg == CNT_W'(1));

endmodule

// File: rtl/printf_integer_formatter.sv
// printf_integer_formatter top level. Depends on pif_pkg, pif_digit_unit and
// printf_integer_formatter_defines.svh.
//
// Takes one format-string byte per item with its 32-bit argument and emits
// output characters, each with a saturating running count that clears after
// the byte flagged string_end. An ordinary byte (and the byte after '%' that
// is a '%' or an unknown specifier) is handled without leaving idle, so such bytes
// stream at one per cycle while out_ready is high. %d, %i and %u hold the
// block for bit-serial shift-and-add-three conversion, then drop leading zero
// digits and emit the rest, always keeping the last digit. The digit register
// always scans all ten positions, whatever the value; a '-' goes out in the
// accepting cycle and costs nothing extra. %x and %X skip the conversion and
// scan the same ten positions (eight nibbles zero-extended); %p also emits
// the "0x" prefix first. A stalled output stretches every emitting state.
`include "printf_integer_formatter_defines.svh"
module printf_integer_formatter
    import pif_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  fmt_char,
    input  logic [31:0] arg_value,
    input  logic        string_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic [31:0] char_count,
    output logic        last_of_run
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DABBLE = 3'd1;
    localparam logic [2:0] ST_PFX    = 3'd2;
    localparam logic [2:0] ST_SKIP   = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic        pending_reg, pending_next;
    logic [31:0] count_reg, count_next, count_inc;
    logic        end_reg, end_next;
    logic        upper_reg, upper_next;

    // output slot: holds one finished character until the sink takes it
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_char_reg, out_char_next;
    logic [31:0] out_count_reg, out_count_next;
    logic        out_last_reg, out_last_next;

    logic             slot_free;
    logic             accept;
    logic             emit, emit_last;
    logic [7:0]       emit_char;
    logic             item_done, fin_end;
    logic [ARG_W-1:0] arg_w, mag;
    logic             neg;
    logic             use_mag;

    pif_dig_cmd_t  cmd;
    pif_dig_stat_t stat;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;

    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 32'd1;

    // magnitude for signed decimal: two's complement of a negative argument
    assign arg_w = arg_value[ARG_W-1:0];
    assign neg   = ARG_SIGNED && arg_w[ARG_W-1];
    assign mag   = neg ? ARG_W'(~arg_w + ARG_W'(1)) : arg_w;

    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg;
        end_next     = end_reg;
        upper_next   = upper_reg;
        cmd          = '0;
        use_mag      = 1'b0;
        emit         = 1'b0;
        emit_last    = 1'b0;
        emit_char    = '0;
        item_done    = 1'b0;
        fin_end      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    end_next = string_end;
                    fin_end  = string_end;
                    if (!pending_reg)
                    begin
                        if (fmt_char == CH_PERCENT)
                        begin
                            // a trailing '%' leaves nothing pending
                            pending_next = !string_end;
                        end
                        else
                        begin
                            emit      = 1'b1;
                            emit_char = fmt_char;
                            emit_last = 1'b1;
                        end
                    end
                    else
                    begin
                        pending_next = 1'b0;
                        case (fmt_char) inside
                            CH_LOWER_D, CH_LOWER_I:
                            begin
                                cmd.load_dec = 1'b1;
                                use_mag      = 1'b1;
                                upper_next   = 1'b0;
                                state_next   = ST_DABBLE;
                                if (neg)
                                begin
                                    emit      = 1'b1;
                                    emit_char = CH_MINUS;
                                end
                            end
                            CH_LOWER_U:
                            begin
                                cmd.load_dec = 1'b1;
                                upper_next   = 1'b0;
                                state_next   = ST_DABBLE;
                            end
                            CH_LOWER_X:
                            begin
                                cmd.load_hex = 1'b1;
                                upper_next   = 1'b0;
                                state_next   = ST_SKIP;
                            end
                            CH_UPPER_X:
                            begin
                                cmd.load_hex = 1'b1;
                                upper_next   = 1'b1;
                                state_next   = ST_SKIP;
                            end
                            CH_LOWER_P:
                            begin
                                cmd.load_hex = 1'b1;
                                upper_next   = 1'b0;
                                emit         = 1'b1;
                                emit_char    = CH_ZERO;
                                state_next   = ST_PFX;
                            end
                            CH_PERCENT:
                            begin
                                emit      = 1'b1;
                                emit_char = CH_PERCENT;
                                emit_last = 1'b1;
                            end
                            default:
                            begin
                                // unknown specifier: consume silently
                            end
                        endcase
                    end
                    item_done = (state_next == ST_IDLE);
                end
            end
            ST_DABBLE:
            begin
                if (stat.dabble_done)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_PFX:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_char  = CH_LOWER_X;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, always keep the last digit
                if (!stat.last_digit && stat.top_digit == 4'd0)
                begin
                    cmd.shift_digit = 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    emit            = 1'b1;
                    emit_char       = digit_char(stat.top_digit, upper_reg);
                    emit_last       = stat.last_digit;
                    cmd.shift_digit = 1'b1;
                    if (stat.last_digit)
                    begin
                        state_next = ST_IDLE;
                        item_done  = 1'b1;
                        fin_end    = end_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        count_next = emit ? count_inc : count_reg;
        if (item_done && fin_end)
        begin
            count_next = '0;
        end
    end

    // output slot
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = emit_char;
            out_count_next = count_inc;
            out_last_next  = emit_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pending_reg   <= 1'b0;
            count_reg     <= '0;
            end_reg       <= 1'b0;
            upper_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            count_reg     <= count_next;
            end_reg       <= end_next;
            upper_reg     <= upper_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg  <= out_char_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

    pif_digit_unit u_digits (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .load_value (use_mag ? mag : arg_w),
        .stat       (stat)
    );

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign char_count  = out_count_reg;
    assign last_of_run = out_last_reg;

    // a pending '%' only ever waits in idle
    `PIF_ASSERT(a_pending_idle, clk, rst_n, pending_reg |-> (state_reg == ST_IDLE))
    // the count restarts after the final character of a string
    `PIF_ASSERT_NEXT(a_count_clear, clk, rst_n, emit && emit_last && item_done && fin_end, count_reg == '0)
    // the conversion holds the sequencer until every bit has gone through
    `PIF_ASSERT_NEXT(a_dabble_hold, clk, rst_n, state_reg == ST_DABBLE && !stat.dabble_done, state_reg == ST_DABBLE)
    // digits are only scanned once the conversion has finished
    `PIF_ASSERT(a_scan_after_dabble, clk, rst_n, (state_reg == ST_SKIP || state_reg == ST_EMIT) |-> stat.dabble_done)

endmodule
